// ----- rtl/mbpcs_pkg.sv -----
// ---------------------------------------------------------------------------
// mbpcs_pkg
// Shared types and constants of the monochrome bitmap command stream core.
// ---------------------------------------------------------------------------
package mbpcs_pkg;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int DIM_W   = 10;
	localparam int CFG_IDX_W = 3;

	// panel command codes
	localparam logic [7:0] CMD_COLUMN_ADDR = 8'h2A;
	localparam logic [7:0] CMD_PAGE_ADDR   = 8'h2B;
	localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_Y,
		ST_SCAN,
		ST_ADD_X,
		ST_EMIT
	} mbpcs_state_t;

	// word slots of one pixel sequence, in emission order
	typedef enum logic [2:0] {
		SLOT_CASET,
		SLOT_X0,
		SLOT_X1,
		SLOT_PASET,
		SLOT_Y0,
		SLOT_Y1,
		SLOT_RAMWR,
		SLOT_COLOR
	} mbpcs_slot_t;

	// one byte's work, handed from the counters to the sequencer
	typedef struct packed {
		logic [BYTE_W-1:0] pixels;   // set bits inside the width, MSB leftmost
		logic [WORD_W-1:0] col_base; // column of the MSB pixel
		logic [WORD_W-1:0] row;
	} mbpcs_job_t;

endpackage

// ----- rtl/mbpcs_if.sv -----
// ---------------------------------------------------------------------------
// mbpcs_if
// Valid/ready channels: bitmap bytes, panel words and register writes.
// ---------------------------------------------------------------------------
interface mbpcs_byte_if
	import mbpcs_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] bitmap_byte;

	modport source(output valid, output bitmap_byte, input ready);
	modport sink(input valid, input bitmap_byte, output ready);
endinterface

interface mbpcs_word_if
	import mbpcs_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic              is_data;
	logic [WORD_W-1:0] word;
	logic              last;

	modport source(output valid, output is_data, output word, output last, input ready);
	modport sink(input valid, input is_data, input word, input last, output ready);
endinterface

interface mbpcs_cfg_if
	import mbpcs_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/mbpcs_ctr.sv -----
// ---------------------------------------------------------------------------
// mbpcs_ctr
// Row and byte counters, geometry clamp and pixel mask for each byte.
// ---------------------------------------------------------------------------
module mbpcs_ctr
	import mbpcs_pkg::*;
#(
	parameter int MAX_SIDE = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] bitmap_byte,
	input  logic [DIM_W-1:0]  bitmap_width,
	input  logic [DIM_W-1:0]  bitmap_height,
	output mbpcs_job_t        job
);

	localparam int GW      = $clog2(MAX_SIDE + 1);
	localparam int CW      = (GW > DIM_W) ? GW : DIM_W;
	localparam int XW      = GW + 1;
	localparam int BPR_MAX = (MAX_SIDE + 7) / 8;
	localparam int BCNT_W  = (BPR_MAX > 1) ? $clog2(BPR_MAX) : 1;
	localparam int ROW_W   = $clog2(MAX_SIDE);

	logic [ROW_W-1:0]  row_q;
	logic [BCNT_W-1:0] byte_q;

	logic [CW-1:0]     side;
	logic [GW-1:0]     w_eff;
	logic [GW-1:0]     h_eff;
	logic [XW-1:0]     per_row;
	logic              empty;
	logic              stale;
	logic [ROW_W-1:0]  row_cur;
	logic [BCNT_W-1:0] byte_cur;
	logic [XW-1:0]     col_base;
	logic [BYTE_W-1:0] mask;
	logic [XW-1:0]     byte_nxt;
	logic [XW-1:0]     row_nxt;

	always_comb begin
		side    = CW'(MAX_SIDE);
		w_eff   = (CW'(bitmap_width) > side) ? GW'(side) : GW'(bitmap_width);
		h_eff   = (CW'(bitmap_height) > side) ? GW'(side) : GW'(bitmap_height);
		per_row = (XW'(w_eff) + XW'(7)) >> 3;
		empty   = (w_eff == '0) || (h_eff == '0);
		// a register write may have left the counters past the new bounds
		stale   = (XW'(row_q) >= XW'(h_eff)) || (XW'(byte_q) >= per_row);
		row_cur  = stale ? '0 : row_q;
		byte_cur = stale ? '0 : byte_q;
		col_base = XW'(byte_cur) << 3;
		for (int b = 0; b < BYTE_W; b++) begin
			mask[BYTE_W-1-b] = bitmap_byte[BYTE_W-1-b] & ((col_base + XW'(b)) < XW'(w_eff));
		end
		byte_nxt = XW'(byte_cur) + XW'(1);
		row_nxt  = XW'(row_cur) + XW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			byte_q <= '0;
		end else if (accept) begin
			if (empty) begin
				row_q  <= '0;
				byte_q <= '0;
			end else if (byte_nxt >= per_row) begin
				byte_q <= '0;
				row_q  <= (row_nxt >= XW'(h_eff)) ? '0 : row_nxt[ROW_W-1:0];
			end else begin
				byte_q <= byte_nxt[BCNT_W-1:0];
				row_q  <= row_cur;
			end
		end
	end

	assign job.pixels   = empty ? '0 : mask;
	assign job.col_base = WORD_W'(col_base);
	assign job.row      = WORD_W'(row_cur);

endmodule

// ----- rtl/mbpcs_seq.sv -----
// ---------------------------------------------------------------------------
// mbpcs_seq
// Pixel sequencer: one shared coordinate adder and an output word register.
// ---------------------------------------------------------------------------
module mbpcs_seq
	import mbpcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mbpcs_job_t        job,
	input  logic [WORD_W-1:0] origin_x,
	input  logic [WORD_W-1:0] origin_y,
	input  logic [WORD_W-1:0] draw_color,
	output logic              idle,
	mbpcs_word_if.source      cmd
);

	mbpcs_state_t      state_q, state_nxt;
	logic [BYTE_W-1:0] pix_q;
	logic [WORD_W-1:0] col_q;
	logic [WORD_W-1:0] row_q;
	logic [2:0]        bit_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	mbpcs_slot_t       slot_q;

	logic              out_valid_q;
	logic              out_is_data_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_last_q;

	logic [WORD_W-1:0] add_a;
	logic [WORD_W-1:0] add_b;
	logic [WORD_W-1:0] add_sum;
	logic [2:0]        lead;
	logic              load;
	logic              word_is_data;
	logic [WORD_W-1:0] word_val;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_nxt = ST_ADD_Y;
			ST_ADD_Y: state_nxt = ST_SCAN;
			ST_SCAN:  state_nxt = (pix_q == '0) ? ST_IDLE : ST_ADD_X;
			ST_ADD_X: state_nxt = ST_EMIT;
			ST_EMIT:  if (load && slot_q == SLOT_COLOR) state_nxt = ST_SCAN;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		idle  = (state_q == ST_IDLE);
		// shared adder: origin_y + row once per byte, origin_x + column per pixel
		add_a = (state_q == ST_ADD_Y) ? origin_y : origin_x;
		add_b = (state_q == ST_ADD_Y) ? row_q : {col_q[WORD_W-1:3], bit_q};
		add_sum = add_a + add_b;

		lead = 3'd0;
		for (int b = BYTE_W - 1; b >= 0; b--) begin
			if (pix_q[BYTE_W-1-b]) lead = 3'(b);
		end

		load = (state_q == ST_EMIT) && (!out_valid_q || cmd.ready);

		word_is_data = 1'b1;
		word_val     = x_q;
		case (slot_q)
			SLOT_CASET: begin
				word_is_data = 1'b0;
				word_val     = WORD_W'(CMD_COLUMN_ADDR);
			end
			SLOT_X0, SLOT_X1: word_val = x_q;
			SLOT_PASET: begin
				word_is_data = 1'b0;
				word_val     = WORD_W'(CMD_PAGE_ADDR);
			end
			SLOT_Y0, SLOT_Y1: word_val = y_q;
			SLOT_RAMWR: begin
				word_is_data = 1'b0;
				word_val     = WORD_W'(CMD_MEM_WRITE);
			end
			SLOT_COLOR: word_val = draw_color;
			default: word_val = x_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			slot_q      <= SLOT_CASET;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
				slot_q      <= mbpcs_slot_t'(slot_q + 3'd1);
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_ADD_X) slot_q <= SLOT_CASET;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					pix_q <= job.pixels;
					col_q <= job.col_base;
					row_q <= job.row;
				end
			end
			ST_ADD_Y: y_q <= add_sum;
			ST_SCAN: begin
				bit_q <= lead;
				// ~lead addresses the bit counted from the MSB
				pix_q[~lead] <= 1'b0;
			end
			ST_ADD_X: x_q <= add_sum;
			default: ;
		endcase
		if (load) begin
			out_is_data_q <= word_is_data;
			out_word_q    <= word_val;
			out_last_q    <= (slot_q == SLOT_COLOR) && (pix_q == '0);
		end
	end

	assign cmd.valid   = out_valid_q;
	assign cmd.is_data = out_is_data_q;
	assign cmd.word    = out_word_q;
	assign cmd.last    = out_last_q;

endmodule

// ----- rtl/mono_bitmap_pixel_command_stream_core.sv -----
// ---------------------------------------------------------------------------
// mono_bitmap_pixel_command_stream_core
// Expands 1-bpp bitmap bytes into panel address/write command sequences.
// ---------------------------------------------------------------------------
//   channel  dir  payload                  handshake
//   cfg      in   index[2:0], data[15:0]   valid/ready, ready always high
//   bitmap   in   bitmap_byte[7:0]         valid/ready
//   cmd      out  is_data, word[15:0], last valid/ready, registered
//
// The shared 16-bit coordinate adder runs once per byte for the row and once
// per set pixel inside the width for the column, and each such pixel then
// emits eight output words. Stalls on cmd hold the sequencer in its emit step.
// bitmap is ready only while the sequencer is idle. Reset clears registers,
// counters and the sequencer.
// ---------------------------------------------------------------------------
module mono_bitmap_pixel_command_stream_core
	import mbpcs_pkg::*;
#(
	parameter int MAX_SIDE = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	mbpcs_cfg_if.sink     cfg,
	mbpcs_byte_if.sink    bitmap,
	mbpcs_word_if.source  cmd
);

	logic [WORD_W-1:0] origin_x_q;
	logic [WORD_W-1:0] origin_y_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [WORD_W-1:0] color_q;

	logic       seq_idle;
	logic       accept;
	mbpcs_job_t job;

	assign cfg.ready    = 1'b1;
	assign bitmap.ready = seq_idle;
	assign accept       = bitmap.valid && seq_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			color_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ORIGIN_X:      origin_x_q <= cfg.data;
				REG_ORIGIN_Y:      origin_y_q <= cfg.data;
				REG_BITMAP_WIDTH:  width_q    <= cfg.data[DIM_W-1:0];
				REG_BITMAP_HEIGHT: height_q   <= cfg.data[DIM_W-1:0];
				REG_DRAW_COLOR:    color_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	mbpcs_ctr #(
		.MAX_SIDE(MAX_SIDE)
	) u_ctr (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.bitmap_byte  (bitmap.bitmap_byte),
		.bitmap_width (width_q),
		.bitmap_height(height_q),
		.job          (job)
	);

	mbpcs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.job       (job),
		.origin_x  (origin_x_q),
		.origin_y  (origin_y_q),
		.draw_color(color_q),
		.idle      (seq_idle),
		.cmd       (cmd)
	);

`ifndef SYNTHESIS
	// an accepted byte keeps the sequencer busy for at least the row add
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(bitmap.valid && bitmap.ready) |=> !bitmap.ready)
		else $error("bitmap ready right after a byte was taken");

	// the closing word of a byte is always the colour
	a_last_is_color: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.last) |-> cmd.is_data)
		else $error("last flag on a command word");

	// command words carry an 8-bit code only
	a_cmd_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && !cmd.is_data) |-> (cmd.word[15:8] == 8'h00))
		else $error("command word with upper byte set");
`endif

endmodule

// ----- sim/tb_mono_bitmap_pixel_command_stream_core.sv -----
// ---------------------------------------------------------------------------
// tb_mono_bitmap_pixel_command_stream_core
// Self-checking bench: bitmap bytes go in, and every panel word that comes
// out is compared against a local pixel-command expander. A table of
// directed steps covers the geometry corners, then random register settings
// and byte streams follow, with random stalls on both sides.
// ---------------------------------------------------------------------------
module tb_mono_bitmap_pixel_command_stream_core;
	import mbpcs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE_LIMIT    = 512;
	localparam int RAND_ITEMS    = 105;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 100;
	localparam int MAX_REPORTS   = 10;
	localparam int CYCLE_LIMIT   = 500_000;
	localparam int NUM_DIR       = 36;

	// indexes past the register file, writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		STEP_REG,   // register write
		STEP_MAP,   // bitmap byte, words from the expander
		STEP_BLANK, // bitmap byte, no words
		STEP_DOT    // bitmap byte, exactly one pixel
	} step_kind_t;

	typedef struct packed {
		step_kind_t           kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [WORD_W-1:0]    val;  // register data or bitmap byte
		logic [WORD_W-1:0]    dot_x;
		logic [WORD_W-1:0]    dot_y;
		logic [WORD_W-1:0]    dot_color;
	} dir_step_t;

	typedef struct packed {
		logic              is_data;
		logic [WORD_W-1:0] word;
		logic              last;
	} cmd_word_t;

	logic clk = 1'b0;
	logic arst_n;

	mbpcs_cfg_if  cfg_ch ();
	mbpcs_byte_if byte_ch ();
	mbpcs_word_if word_ch ();

	mono_bitmap_pixel_command_stream_core #(
		.MAX_SIDE(SIDE_LIMIT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.bitmap(byte_ch),
		.cmd   (word_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// expander state
	logic [WORD_W-1:0] reg_ox, reg_oy, reg_color;
	logic [DIM_W-1:0]  reg_w, reg_h;
	int unsigned       cur_row, cur_byte;

	cmd_word_t   expected_words[$];
	cmd_word_t   got_w, want_w;
	int unsigned fail_count;
	int unsigned words_seen;
	int unsigned cycle_count;
	int unsigned sink_hold;
	bit          burst_mode;
	bit          bytes_pending;

	dir_step_t dir_tab [NUM_DIR];

	function automatic cmd_word_t cmd_word(input logic is_data, input logic [WORD_W-1:0] value,
			input logic tail);
		return {is_data, value, tail};
	endfunction

	function automatic void push_pixel(input logic [WORD_W-1:0] px, input logic [WORD_W-1:0] py,
			input logic [WORD_W-1:0] color, input logic tail);
		expected_words.push_back(cmd_word(1'b0, {8'h00, CMD_COLUMN_ADDR}, 1'b0));
		expected_words.push_back(cmd_word(1'b1, px, 1'b0));
		expected_words.push_back(cmd_word(1'b1, px, 1'b0));
		expected_words.push_back(cmd_word(1'b0, {8'h00, CMD_PAGE_ADDR}, 1'b0));
		expected_words.push_back(cmd_word(1'b1, py, 1'b0));
		expected_words.push_back(cmd_word(1'b1, py, 1'b0));
		expected_words.push_back(cmd_word(1'b0, {8'h00, CMD_MEM_WRITE}, 1'b0));
		expected_words.push_back(cmd_word(1'b1, color, tail));
	endfunction

	function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
		case (idx)
			REG_ORIGIN_X:      reg_ox = d;
			REG_ORIGIN_Y:      reg_oy = d;
			REG_BITMAP_WIDTH:  reg_w = d[DIM_W-1:0];
			REG_BITMAP_HEIGHT: reg_h = d[DIM_W-1:0];
			REG_DRAW_COLOR:    reg_color = d;
			default: ;
		endcase
	endfunction

	// one bitmap byte -> pixel command words, advances row/byte counters
	function automatic void expand_byte(input logic [BYTE_W-1:0] pix);
		int unsigned w, h, per_row, col, k, last_k;
		logic [WORD_W-1:0] py;
		w = (reg_w > SIDE_LIMIT) ? SIDE_LIMIT : reg_w;
		h = (reg_h > SIDE_LIMIT) ? SIDE_LIMIT : reg_h;
		per_row = (w + 7) / 8;
		if (w == 0 || h == 0) begin
			cur_row = 0;
			cur_byte = 0;
			return;
		end
		// counters left past a shrunk geometry: start a new bitmap
		if (cur_row >= h || cur_byte >= per_row) begin
			cur_row = 0;
			cur_byte = 0;
		end
		last_k = 8;
		for (k = 0; k < 8; k++)
			if (cur_byte * 8 + k < w && pix[7-k])
				last_k = k;
		py = reg_oy + 16'(cur_row);
		for (k = 0; k < 8; k++) begin
			col = cur_byte * 8 + k;
			if (col < w && pix[7-k])
				push_pixel(reg_ox + 16'(col), py, reg_color, k == last_k);
		end
		cur_byte++;
		if (cur_byte >= per_row) begin
			cur_byte = 0;
			cur_row++;
			if (cur_row >= h)
				cur_row = 0;
		end
	endfunction

	function automatic void note_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endfunction

	function automatic int unsigned draw_wait();
		return burst_mode ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic logic [WORD_W-1:0] pick_edge16();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly small sides, now and then empty, full or oversized
	function automatic logic [WORD_W-1:0] pick_dim(input int unsigned small_max);
		case ($urandom_range(0, 15))
			0: return 16'd0;
			1: return 16'(SIDE_LIMIT);
			2: return 16'($urandom_range(SIDE_LIMIT + 1, 65535));
			default: return 16'($urandom_range(1, small_max));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// hold off bitmap requests until every word is back and the core is idle
	task automatic drain_words();
		byte_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		bytes_pending = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
		if (bytes_pending)
			drain_words();
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		set_reg(idx, d);
	endtask

	// valid stays high after acceptance, the next call lowers it only for a gap
	task automatic send_byte(input logic [BYTE_W-1:0] b, input dir_step_t typed);
		int unsigned gap;
		int unsigned n0;
		gap = draw_wait();
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.bitmap_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_pending = 1'b1;
		n0 = expected_words.size();
		expand_byte(b);
		if (typed.kind != STEP_MAP) begin
			while (expected_words.size() > n0)
				void'(expected_words.pop_back());
			if (typed.kind == STEP_DOT)
				push_pixel(typed.dot_x, typed.dot_y, typed.dot_color, 1'b1);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (word_ch.valid && word_ch.ready) begin
				got_w = {word_ch.is_data, word_ch.word, word_ch.last};
				if (expected_words.size() == 0) begin
					note_fail($sformatf("word %0d: none expected, got is_data=%0b word=%h last=%0b",
						words_seen, got_w.is_data, got_w.word, got_w.last));
				end else begin
					want_w = expected_words.pop_front();
					if (got_w.is_data !== want_w.is_data || got_w.word !== want_w.word ||
							got_w.last !== want_w.last)
						note_fail($sformatf({"word %0d: expected is_data=%0b word=%h last=%0b,",
							" got is_data=%0b word=%h last=%0b"}, words_seen, want_w.is_data,
							want_w.word, want_w.last, got_w.is_data, got_w.word, got_w.last));
				end
				words_seen++;
				sink_hold = draw_wait();
			end else if (sink_hold != 0) begin
				sink_hold--;
			end
			word_ch.ready <= (sink_hold == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** mono_bitmap_pixel_command_stream_core: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned i, n_bytes, items_done;
		dir_step_t map_step;

		arst_n              = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		byte_ch.valid       = 1'b0;
		byte_ch.bitmap_byte = '0;
		word_ch.ready       = 1'b0;
		fail_count    = 0;
		words_seen    = 0;
		cycle_count   = 0;
		sink_hold     = 0;
		burst_mode    = 1'b0;
		bytes_pending = 1'b0;
		items_done    = 0;
		reg_ox = '0; reg_oy = '0; reg_color = '0; reg_w = '0; reg_h = '0;
		cur_row = 0; cur_byte = 0;
		map_step = '{STEP_MAP, '0, '0, '0, '0, '0};

		dir_tab = '{
			// geometry is empty after reset
			'{STEP_BLANK, '0, 16'h00FF, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_BITMAP_WIDTH, 16'd8, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_BITMAP_HEIGHT, 16'd2, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_ORIGIN_X, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_ORIGIN_Y, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_DRAW_COLOR, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_DOT, '0, 16'h0080, 16'h0000, 16'h0000, 16'hFFFF},
			'{STEP_DOT, '0, 16'h0001, 16'h0007, 16'h0001, 16'hFFFF},
			'{STEP_BLANK, '0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_MAP, '0, 16'h00FF, 16'h0000, 16'h0000, 16'h0000},
			// origin at the far corner, coordinates wrap
			'{STEP_REG, REG_ORIGIN_X, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_ORIGIN_Y, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_DRAW_COLOR, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_DOT, '0, 16'h0080, 16'hFFFF, 16'hFFFF, 16'h0000},
			'{STEP_DOT, '0, 16'h0040, 16'h0000, 16'h0000, 16'h0000},
			// width saturates, height keeps only its low 10 bits
			'{STEP_REG, REG_BITMAP_WIDTH, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_BITMAP_HEIGHT, 16'hFC01, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_SPARE_LO, 16'hABCD, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_SPARE_HI, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_MAP, '0, 16'h0055, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_MAP, '0, 16'h00AA, 16'h0000, 16'h0000, 16'h0000},
			// byte counter now past the narrower row
			'{STEP_REG, REG_BITMAP_WIDTH, 16'd3, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_MAP, '0, 16'h00FF, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_BITMAP_WIDTH, 16'd0, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_BLANK, '0, 16'h00FF, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_BITMAP_WIDTH, 16'd9, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_BITMAP_HEIGHT, 16'd0, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_BLANK, '0, 16'h0081, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_BITMAP_HEIGHT, 16'h03FF, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_ORIGIN_X, 16'h000A, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_ORIGIN_Y, 16'h0014, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_REG, REG_DRAW_COLOR, 16'h1234, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_MAP, '0, 16'h007F, 16'h0000, 16'h0000, 16'h0000},
			'{STEP_DOT, '0, 16'h0080, 16'h0012, 16'h0014, 16'h1234},
			'{STEP_DOT, '0, 16'h0040, 16'h000B, 16'h0015, 16'h1234},
			// only padding bits set in the second byte of a 9-wide row
			'{STEP_BLANK, '0, 16'h007F, 16'h0000, 16'h0000, 16'h0000}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < NUM_DIR; i++) begin
			if (dir_tab[i].kind == STEP_REG)
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			else
				send_byte(dir_tab[i].val[BYTE_W-1:0], dir_tab[i]);
		end

		// first random phase runs with no idling on either side
		burst_mode = 1'b1;
		while (items_done < RAND_ITEMS) begin
			write_reg(REG_ORIGIN_X, pick_edge16());
			write_reg(REG_ORIGIN_Y, pick_edge16());
			write_reg(REG_BITMAP_WIDTH, pick_dim(20));
			write_reg(REG_BITMAP_HEIGHT, pick_dim(5));
			write_reg(REG_DRAW_COLOR, pick_edge16());
			if ($urandom_range(0, 3) == 0)
				write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
			n_bytes = (reg_w == 0 || reg_h == 0) ? 3 : $urandom_range(8, 24);
			for (i = 0; i < n_bytes; i++) begin
				if (i == n_bytes / 2 && $urandom_range(0, 2) == 0)
					drain_words();
				if (reg_w != 0 && reg_h != 0)
					items_done++;
				send_byte(pick_byte(), map_step);
			end
			burst_mode = ($urandom_range(0, 3) == 0);
		end

		drain_words();
		repeat (END_CYCLES) @(posedge clk);
		if (expected_words.size() != 0)
			note_fail($sformatf("%0d words never arrived", expected_words.size()));

		if (fail_count == 0)
			$display("** mono_bitmap_pixel_command_stream_core: PASSED **");
		else
			$display("** mono_bitmap_pixel_command_stream_core: FAILED **");
		$finish;
	end

endmodule
